### src/ahcfp_pkg.sv
// ----------------------------------------------------------------------------
// ahcfp_pkg
// shared types and constants of the ascii hex can frame parser
// ----------------------------------------------------------------------------
package ahcfp_pkg;

  // default number of data bytes per frame
  localparam int unsigned DATA_BYTES_DEF = 8;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ID_W     = 12;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned FDATA_W  = 64;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned POS_W    = 5;

  // first data digit position
  localparam logic [POS_W-1:0] POS_DATA = POS_W'(4);
  // last identifier digit position
  localparam logic [POS_W-1:0] POS_ID_LAST = POS_W'(3);

  // special characters
  localparam logic [CHAR_W-1:0] CHAR_START = 8'h69;  // 'i'
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;  // carriage return

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_START   = 3'd0,
    ST_DIGIT   = 3'd1,
    ST_DONE    = 3'd2,
    ST_NOSTART = 3'd3,
    ST_NOHEX   = 3'd4,
    ST_NOCR    = 3'd5
  } status_e;

  // classified character handed from front to back
  typedef struct packed {
    logic             is_start;
    logic             is_cr;
    logic             is_hex;
    logic [NIB_W-1:0] nibble;
  } class_t;

endpackage

### src/ascii_hex_can_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_hex_can_frame_parser_core
// parses ascii transmit commands of a serial can adapter into frames
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue: drive rx_byte_i with push high; the item is taken
//   at a clock edge where push is high and full is low. each received
//   character gives exactly one result item.
//   result side is a queue: while empty is low the oldest result sits on
//   status_o, echo_space_o, frame_id_o, frame_length_o and frame_data_o; it
//   is taken at an edge where pop is high. frame fields are zero unless the
//   status is frame complete.
//   an accepted item passes through the queue and then the result register;
//   empty goes low once the result register has loaded it.
//   the parser state is updated once per accepted character, so one item
//   per cycle is sustained on both sides while pop stays high.
//   when pop stays low the result register holds, the front queue
//   (2 entries) fills and then full rises; nothing is dropped.
//   reset clears the parser to idle, empties the queue and the result
//   register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ascii_hex_can_frame_parser_core #(
  parameter int unsigned DATA_BYTES = ahcfp_pkg::DATA_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [ahcfp_pkg::CHAR_W-1:0]   rx_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [ahcfp_pkg::STATUS_W-1:0] status_o,
  output logic                           echo_space_o,
  output logic [ahcfp_pkg::ID_W-1:0]     frame_id_o,
  output logic [ahcfp_pkg::LEN_W-1:0]    frame_length_o,
  output logic [ahcfp_pkg::FDATA_W-1:0]  frame_data_o
);
  import ahcfp_pkg::*;

  class_t cls_in;
  class_t cls_q;
  logic   q_empty;
  logic   back_ready;

  // classify incoming characters
  ahcfp_front u_front (
    .rx_byte_i (rx_byte_i),
    .cls_o     (cls_in)
  );

  // decoupling queue
  ahcfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (back_ready),
    .data_o  (cls_q),
    .empty_o (q_empty)
  );

  // parser and result register
  ahcfp_back #(
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (!q_empty),
    .cls_i          (cls_q),
    .in_ready_o     (back_ready),
    .empty_o        (empty),
    .pop_i          (pop),
    .status_o       (status_o),
    .echo_space_o   (echo_space_o),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .frame_data_o   (frame_data_o)
  );

endmodule

### src/ahcfp_front.sv
// ----------------------------------------------------------------------------
// ahcfp_front
// character classifier: start, carriage return, hex digit and its value
// ----------------------------------------------------------------------------
module ahcfp_front (
  input  logic [ahcfp_pkg::CHAR_W-1:0] rx_byte_i,
  output ahcfp_pkg::class_t            cls_o
);
  import ahcfp_pkg::*;

  logic [CHAR_W-1:0] dec_off;
  logic [CHAR_W-1:0] lc_off;
  logic [CHAR_W-1:0] uc_off;

  // offsets from each digit range base
  assign dec_off = rx_byte_i - 8'h30;
  assign lc_off  = rx_byte_i - 8'h61;
  assign uc_off  = rx_byte_i - 8'h41;

  // hex decode
  always_comb begin
    cls_o.is_start = (rx_byte_i == CHAR_START);
    cls_o.is_cr    = (rx_byte_i == CHAR_CR);
    cls_o.is_hex   = 1'b0;
    cls_o.nibble   = '0;
    if (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) begin
      cls_o.is_hex = 1'b1;
      cls_o.nibble = dec_off[NIB_W-1:0];
    end else if (rx_byte_i >= 8'h61 && rx_byte_i <= 8'h66) begin
      cls_o.is_hex = 1'b1;
      cls_o.nibble = lc_off[NIB_W-1:0] + NIB_W'(10);
    end else if (rx_byte_i >= 8'h41 && rx_byte_i <= 8'h46) begin
      cls_o.is_hex = 1'b1;
      cls_o.nibble = uc_off[NIB_W-1:0] + NIB_W'(10);
    end
  end

endmodule

### src/ahcfp_queue.sv
// ----------------------------------------------------------------------------
// ahcfp_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module ahcfp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ahcfp_pkg::class_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output ahcfp_pkg::class_t data_o,
  output logic              empty_o
);
  import ahcfp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  class_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/ahcfp_back.sv
// ----------------------------------------------------------------------------
// ahcfp_back
// frame parser state and result register
// ----------------------------------------------------------------------------
module ahcfp_back #(
  parameter int unsigned DATA_BYTES = ahcfp_pkg::DATA_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  ahcfp_pkg::class_t              cls_i,
  output logic                           in_ready_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [ahcfp_pkg::STATUS_W-1:0] status_o,
  output logic                           echo_space_o,
  output logic [ahcfp_pkg::ID_W-1:0]     frame_id_o,
  output logic [ahcfp_pkg::LEN_W-1:0]    frame_length_o,
  output logic [ahcfp_pkg::FDATA_W-1:0]  frame_data_o
);
  import ahcfp_pkg::*;

  localparam int unsigned DW = DATA_BYTES * 8;
  localparam logic [POS_W-1:0] POS_END = POS_W'(4 + 2 * DATA_BYTES);

  // parser state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ID_W-1:0]   ident_q, ident_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]     data_q, data_d;

  // result register
  logic              valid_q;
  status_e           status_q, status_d;
  logic              space_q, space_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [FDATA_W-1:0] fdata_q, fdata_d;

  logic              fire;

  assign in_ready_o = !valid_q || pop_i;
  assign fire       = in_valid_i && in_ready_o;

  // next state and result for one item
  always_comb begin
    pos_d    = pos_q;
    ident_d  = ident_q;
    cnt_d    = cnt_q;
    data_d   = data_q;
    status_d = ST_NOSTART;
    space_d  = 1'b0;
    id_d     = '0;
    len_d    = '0;
    fdata_d  = '0;
    if (pos_q == '0) begin
      // idle: clear frame, wait for start
      ident_d = '0;
      cnt_d   = '0;
      data_d  = '0;
      if (cls_i.is_start) begin
        pos_d    = POS_W'(1);
        status_d = ST_START;
      end
    end else if (pos_q < POS_DATA) begin
      // identifier digits
      if (!cls_i.is_hex) begin
        pos_d    = '0;
        status_d = ST_NOHEX;
      end else begin
        space_d  = (pos_q == POS_ID_LAST);
        ident_d  = {ident_q[ID_W-NIB_W-1:0], cls_i.nibble};
        pos_d    = pos_q + POS_W'(1);
        status_d = ST_DIGIT;
      end
    end else if (cls_i.is_cr) begin
      // frame complete
      pos_d    = '0;
      status_d = ST_DONE;
      id_d     = ident_q;
      len_d    = cnt_q;
      fdata_d[DW-1:0] = data_q;
    end else if (pos_q < POS_END) begin
      // data digits, new byte at even position
      if (!cls_i.is_hex) begin
        pos_d    = '0;
        status_d = ST_NOHEX;
      end else begin
        if (pos_q[0]) begin
          space_d = 1'b1;
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
        for (int j = 0; j < DATA_BYTES; j++) begin
          if (cnt_d == LEN_W'(j + 1)) begin
            data_d[j*8 +: 8] = {data_q[j*8 +: NIB_W], cls_i.nibble};
          end
        end
        pos_d    = pos_q + POS_W'(1);
        status_d = ST_DIGIT;
      end
    end else begin
      // data full, only cr allowed
      pos_d    = '0;
      status_d = ST_NOCR;
    end
  end

  // parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ident_q <= '0;
      cnt_q   <= '0;
      data_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pos_q   <= pos_d;
        ident_q <= ident_d;
        cnt_q   <= cnt_d;
        data_q  <= data_d;
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      space_q  <= space_d;
      id_q     <= id_d;
      len_q    <= len_d;
      fdata_q  <= fdata_d;
    end
  end

  assign empty_o        = !valid_q;
  assign status_o       = status_q;
  assign echo_space_o   = space_q;
  assign frame_id_o     = id_q;
  assign frame_length_o = len_q;
  assign frame_data_o   = fdata_q;

endmodule

### sim/ascii_hex_can_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_hex_can_frame_parser_core_tb
// self-checking bench for the ascii hex can frame parser core
// ----------------------------------------------------------------------------
// characters are pushed one item at a time and run through a parser model
// kept in the bench; every popped result is compared field by field with the
// oldest predicted outcome. directed characters come first, then random
// transmit commands (well-formed, truncated, corrupted, plus line noise) with
// random gaps on both sides, a long result hold-off that backs up the input,
// and pauses where the sender waits for all results to drain.
// ----------------------------------------------------------------------------
module ascii_hex_can_frame_parser_core_tb;
  import ahcfp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [POS_W-1:0] POS_WAIT_CR = POS_DATA + POS_W'(2 * DATA_BYTES_DEF);
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;  // 'A'

  // one parser outcome
  typedef struct {
    status_e            status;
    logic               space;
    logic [ID_W-1:0]    ident;
    logic [LEN_W-1:0]   len;
    logic [FDATA_W-1:0] bytes;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [CHAR_W-1:0]   rx_byte;
  logic                empty;
  logic                pop;
  logic [STATUS_W-1:0] status_o;
  logic                echo_space_o;
  logic [ID_W-1:0]     frame_id_o;
  logic [LEN_W-1:0]    frame_length_o;
  logic [FDATA_W-1:0]  frame_data_o;

  // parser model state
  logic [POS_W-1:0]  parse_pos   = '0;
  logic [ID_W-1:0]   parse_ident = '0;
  logic [LEN_W-1:0]  parse_bytes = '0;
  logic [7:0]        parse_data [DATA_BYTES_DEF];

  outcome_t parse_outcomes[$];

  int  items_sent       = 0;
  int  results_checked  = 0;
  int  frames_completed = 0;
  int  full_cycles      = 0;
  int  err_count        = 0;
  int  cycle_count      = 0;
  int  hold_request     = 0;
  bit  send_gaps_on     = 1'b0;
  bit  recv_gaps_on     = 1'b0;

  ascii_hex_can_frame_parser_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .echo_space_o   (echo_space_o),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .frame_data_o   (frame_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hex digit decode: {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'b0;
  endfunction

  // advance the parser model by one character and return its outcome
  function automatic outcome_t parse_char(input logic [CHAR_W-1:0] c);
    outcome_t   o;
    logic [4:0] hx;
    logic [2:0] k;
    logic       done;
    o = '{status: ST_NOSTART, space: 1'b0, ident: '0, len: '0, bytes: '0};
    done = 1'b0;
    hx = hex_nibble(c);
    if (parse_pos == '0) begin
      // idle clears the frame on every character
      parse_ident = '0;
      parse_bytes = '0;
      for (int j = 0; j < DATA_BYTES_DEF; j++) parse_data[j] = '0;
      if (c == CHAR_START) begin
        parse_pos = POS_W'(1);
        o.status = ST_START;
      end else begin
        o.status = ST_NOSTART;
      end
    end else if (parse_pos < POS_DATA) begin
      // identifier digits, cr is not accepted here
      if (!hx[4]) begin
        parse_pos = '0;
        o.status = ST_NOHEX;
      end else begin
        o.space = (parse_pos == POS_ID_LAST);
        parse_ident = {parse_ident[ID_W-5:0], hx[3:0]};
        parse_pos++;
        o.status = ST_DIGIT;
      end
    end else if (c == CHAR_CR) begin
      parse_pos = '0;
      o.status = ST_DONE;
      done = 1'b1;
    end else if (parse_pos < POS_WAIT_CR) begin
      // data digits, even position opens a new byte
      if (!hx[4]) begin
        parse_pos = '0;
        o.status = ST_NOHEX;
      end else begin
        if (parse_pos[0]) o.space = 1'b1;
        else parse_bytes++;
        k = 3'(parse_bytes - 1'b1);
        parse_data[k] = {parse_data[k][3:0], hx[3:0]};
        parse_pos++;
        o.status = ST_DIGIT;
      end
    end else begin
      // data full, only cr may follow
      parse_pos = '0;
      o.status = ST_NOCR;
    end
    if (done) begin
      o.ident = parse_ident;
      o.len = parse_bytes;
      for (int j = 0; j < DATA_BYTES_DEF; j++) o.bytes[8*j +: 8] = parse_data[j];
      frames_completed++;
    end
    return o;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CHAR_ZERO + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(v - 10);
  endfunction

  // offer one character, wait for acceptance, record its predicted outcome
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = pick_gap(send_gaps_on);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    rx_byte = c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    parse_outcomes.push_back(parse_char(c));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (parse_outcomes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // transmit command with random content, sometimes corrupted or truncated
  task automatic send_random_frame();
    logic [CHAR_W-1:0] chars[$];
    int ndig;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_char(CHAR_W'($urandom_range(0, 255)));
    end
    chars.push_back(CHAR_START);
    repeat (3) chars.push_back(rand_hex_char());
    ndig = ($urandom_range(0, 4) == 0) ? 2 * DATA_BYTES_DEF
                                       : $urandom_range(0, 2 * DATA_BYTES_DEF);
    repeat (ndig) chars.push_back(rand_hex_char());
    r = $urandom_range(0, 99);
    chars.push_back((r < 85) ? CHAR_CR : CHAR_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      chars[$urandom_range(0, chars.size() - 1)] = CHAR_W'($urandom_range(0, 255));
    end
    foreach (chars[k]) send_char(chars[k]);
  endtask

  // field extremes, every status but no-cr, and the named corner cases
  task automatic test_directed_chars();
    logic [CHAR_W-1:0] seq[$] = '{
      8'h00, 8'hFF,                              // not start
      "i", "A", "f", "9", CHAR_CR,               // cr right after identifier
      "i", ":",                                  // bad identifier digit
      "i", CHAR_CR,                              // cr inside identifier
      "i", "1", "2", "3", "F", "a", "d", CHAR_CR, // odd data digit count
      "i", "0", "0", "0", "G"                    // bad data digit
    };
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    foreach (seq[k]) send_char(seq[k]);
  endtask

  task automatic test_random_traffic(input int count, input bit sgaps, input bit rgaps);
    int start;
    start = items_sent;
    send_gaps_on = sgaps;
    recv_gaps_on = rgaps;
    while (items_sent - start < count) send_random_frame();
  endtask

  // results held back long enough for full to stall the input
  task automatic test_receiver_hold();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b1;
    hold_request = 300;
    repeat (4) send_random_frame();
  endtask

  // sender stops after each frame until every result is back
  task automatic test_drain_pause();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    repeat (6) begin
      send_random_frame();
      push = 1'b0;
      wait_results_drained();
    end
  endtask

  // result side: pop with random stalls and an optional long hold-off
  initial begin : result_sink
    int r;
    int stall_left;
    int hold_left;
    pop = 1'b0;
    stall_left = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop = 1'b0;
      end else if (!recv_gaps_on) begin
        pop = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          pop = 1'b1;
        end else begin
          pop = 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // compare each popped result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && full) full_cycles++;
    if (rst_ni && pop && !empty) begin
      if (parse_outcomes.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing expected, expected none, actual status %0d",
                 $time, status_o);
      end else begin
        want = parse_outcomes.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("echo_space", 64'(want.space), 64'(echo_space_o));
        check_field("frame_id", 64'(want.ident), 64'(frame_id_o));
        check_field("frame_length", 64'(want.len), 64'(frame_length_o));
        check_field("frame_data", want.bytes, frame_data_o);
        results_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, parse_outcomes.size());
      $display("ascii_hex_can_frame_parser_core verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    push = 1'b0;
    rx_byte = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_chars();
    test_random_traffic(700, 1'b1, 1'b1);
    test_receiver_hold();
    test_random_traffic(400, 1'b0, 1'b0);
    test_drain_pause();
    test_random_traffic(600, 1'b1, 1'b1);
    push = 1'b0;
    wait_results_drained();

    $display("run: %0d characters pushed, %0d results checked, %0d frames completed",
             items_sent, results_checked, frames_completed);
    $display("run: input stalled by full for %0d cycles, %0d mismatches",
             full_cycles, err_count);
    if (err_count == 0) begin
      $display("ascii_hex_can_frame_parser_core verification clean");
    end else begin
      $display("ascii_hex_can_frame_parser_core verification failed");
    end
    $finish;
  end

endmodule
